// ----- hw/rtl/gfls_pkg.sv -----
// Shared types and constants for the prime-field consistency checker.
package gfls_pkg;

	localparam int WORD_W = 32;
	localparam int WIDE_W = 2 * WORD_W;
	localparam int DST_W = 2;
	localparam int INFLIGHT_W = 8;
	localparam int POW_CNT_W = $clog2(WORD_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [WORD_W-1:0] MODULUS_RESET = 32'hFFFF_FFFB;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_COUNT = 2'd2;

	// Where a reduced result goes when it leaves the cell chain.
	typedef enum logic [DST_W-1:0] {
		DST_MEM,
		DST_BASE,
		DST_ACC
	} dst_t;

	// One multiply-add request: a + f * b, reduced modulo the field prime.
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] f;
		logic [WORD_W-1:0] b;
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DRAIN,
		S_FILL,
		S_COL,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_PIVOT,
		S_SWAP_RD,
		S_SWAP_WR0,
		S_SWAP_WR1,
		S_POW_RD,
		S_POW_LD,
		S_POW_ISS0,
		S_POW_ISS1,
		S_POW_WAIT,
		S_SCALE_RD,
		S_SCALE_ISS,
		S_SCALE_WAIT,
		S_ELIM_ROW,
		S_ELIM_LEAD,
		S_ELIM_RD,
		S_ELIM_ISS,
		S_ELIM_WAIT,
		S_DONE
	} state_t;

endpackage

// ----- hw/rtl/gfls_cell.sv -----
// One restoring-remainder cell: shifts in one dividend bit, subtracts the modulus when it fits.
module gfls_cell #(
	parameter int TW = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [gfls_pkg::WORD_W-1:0] m,
	input  logic                       in_valid,
	input  logic [gfls_pkg::WORD_W-1:0] in_rem,
	input  logic [gfls_pkg::WIDE_W-1:0] in_val,
	input  logic [TW-1:0]              in_tag,
	output logic                       out_valid,
	output logic [gfls_pkg::WORD_W-1:0] out_rem,
	output logic [gfls_pkg::WIDE_W-1:0] out_val,
	output logic [TW-1:0]              out_tag
);
	import gfls_pkg::*;

	logic [WORD_W:0] shifted;
	logic [WORD_W:0] diff;
	logic [WORD_W-1:0] rem_n;

	assign shifted = {in_rem, in_val[WIDE_W-1]};
	assign diff = shifted - {1'b0, m};
	assign rem_n = (shifted >= {1'b0, m}) ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_rem <= rem_n;
		out_val <= {in_val[WIDE_W-2:0], 1'b0};
		out_tag <= in_tag;
	end

endmodule

// ----- hw/rtl/gfls_modred.sv -----
// Multiply-add front end followed by the chain of remainder cells.
module gfls_modred #(
	parameter int TW = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [gfls_pkg::WORD_W-1:0] m,
	input  logic                       in_valid,
	input  gfls_pkg::op_t              in_op,
	input  logic [TW-1:0]              in_tag,
	output logic                       out_valid,
	output logic [gfls_pkg::WORD_W-1:0] out_rem,
	output logic [TW-1:0]              out_tag
);
	import gfls_pkg::*;

	localparam int NCELL = WIDE_W;

	logic              v_s1;
	op_t               op_s1;
	logic [TW-1:0]     tag_s1;
	logic              v_s2;
	logic [WIDE_W-1:0] prod_s2;
	logic [WORD_W-1:0] a_s2;
	logic [TW-1:0]     tag_s2;

	logic              ch_v   [0:NCELL];
	logic [WORD_W-1:0] ch_rem [0:NCELL];
	logic [WIDE_W-1:0] ch_val [0:NCELL];
	logic [TW-1:0]     ch_tag [0:NCELL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= in_op;
		tag_s1  <= in_tag;
		prod_s2 <= WIDE_W'(op_s1.f) * WIDE_W'(op_s1.b);
		a_s2    <= op_s1.a;
		tag_s2  <= tag_s1;
	end

	// a + f*b stays below 2^64, so the sum needs no carry-out bit.
	assign ch_v[0]   = v_s2;
	assign ch_rem[0] = '0;
	assign ch_val[0] = prod_s2 + WIDE_W'(a_s2);
	assign ch_tag[0] = tag_s2;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		gfls_cell #(.TW(TW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.m        (m),
			.in_valid (ch_v[k]),
			.in_rem   (ch_rem[k]),
			.in_val   (ch_val[k]),
			.in_tag   (ch_tag[k]),
			.out_valid(ch_v[k+1]),
			.out_rem  (ch_rem[k+1]),
			.out_val  (ch_val[k+1]),
			.out_tag  (ch_tag[k+1])
		);
	end

	assign out_valid = ch_v[NCELL];
	assign out_rem   = ch_rem[NCELL];
	assign out_tag   = ch_tag[NCELL];

endmodule

// ----- hw/rtl/gfls_store.sv -----
// Matrix store: one write port, two registered read ports.
module gfls_store #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [gfls_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]              raddr0,
	input  logic [AW-1:0]              raddr1,
	output logic [gfls_pkg::WORD_W-1:0] rdata0,
	output logic [gfls_pkg::WORD_W-1:0] rdata1
);
	import gfls_pkg::*;

	logic [WORD_W-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ----- hw/rtl/gf_p_linear_system_consistency_core.sv -----
// Consistency check of a linear system over a prime field by forward elimination.
//
// Configure modulus (index 0), row_count (1) and unknown_count (2) over the cfg
// channel while the block is idle. Then feed the augmented matrix row by row,
// unknown_count+1 words per row, one word per start pulse taken while busy is low.
// Raise last_entry on the final word. Words are reduced modulo the prime in a
// 66-stage pipe (two multiply-add stages and 64 remainder cells), so loading
// takes one word per cycle. After the last word busy stays high while the pipe
// drains, missing positions are zeroed one per cycle, and elimination runs.
// Per column: rows are searched for a pivot, pivot-row words are swapped into
// place when needed, the inverse takes 32 square-and-multiply rounds, the pivot
// row's words are scaled, and the words of each row below are cleared, with a
// pipe drain after scaling and after clearing. The result is shown on
// consistent for one cycle with done high; the receiver cannot stall it. Reset
// empties the pipe, returns to idle and loads the register defaults; store
// contents are left as they were.
module gf_p_linear_system_consistency_core #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [31:0]                   entry,
	input  logic                          last_entry,
	output logic                          done,
	output logic                          consistent,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gfls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gfls_pkg::WORD_W-1:0]    cfg_data
);
	import gfls_pkg::*;

	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int LPW = $clog2(STORE_DEPTH + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int TW = AW + DST_W;

	state_t state_q, state_n;

	logic [WORD_W-1:0]     m_q;
	logic [6:0]            rc_q;
	logic [5:0]            nu_q;
	logic [LPW-1:0]        load_pos_q;
	logic [RW-1:0]         rank_q, i_q, piv_q;
	logic [CW-1:0]         col_q, j_q;
	logic [WORD_W-1:0]     base_q, acc_q, f_q, tmp_q, exp_q;
	logic [POW_CNT_W-1:0]  pow_cnt_q;
	logic                  ok_q;
	logic [INFLIGHT_W-1:0] inflight_q;

	logic [RW-1:0]  rows_eff;
	logic [CW-1:0]  nu_eff, width_eff;
	logic [LPW-1:0] total;
	logic           m_small;
	logic           load_room;
	logic           fill_more;
	logic           i_last;

	logic [RW-1:0] row0;
	logic [CW-1:0] col0;
	logic [AW-1:0] addr0, addr1;

	logic              op_valid;
	op_t               op;
	dst_t              op_dst;
	logic [AW-1:0]     op_addr;
	logic              red_valid;
	logic [WORD_W-1:0] red_rem;
	logic [TW-1:0]     red_tag;
	dst_t              red_dst;
	logic [AW-1:0]     red_addr;

	logic              ctrl_we, chain_we, we;
	logic [AW-1:0]     ctrl_waddr, waddr;
	logic [WORD_W-1:0] ctrl_wdata, wdata;
	logic [WORD_W-1:0] rdata0, rdata1;

	assign rows_eff  = (32'(rc_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rc_q);
	assign nu_eff    = (32'(nu_q) > MAX_COLUMNS - 1) ? CW'(MAX_COLUMNS - 1) : CW'(nu_q);
	assign width_eff = nu_eff + CW'(1);
	assign total     = LPW'(32'(rows_eff) * 32'(width_eff));
	assign m_small   = (m_q < 32'd2);
	assign load_room = (load_pos_q < LPW'(STORE_DEPTH));
	assign fill_more = (load_pos_q < total);
	assign i_last    = (32'(i_q) + 1 >= 32'(rows_eff));

	assign addr0 = AW'(32'(row0) * 32'(width_eff) + 32'(col0));
	assign addr1 = AW'(32'(rank_q) * 32'(width_eff) + 32'(j_q));

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && (inflight_q == '0);
	assign done      = (state_q == S_DONE);
	assign consistent = ok_q;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && last_entry) state_n = S_DRAIN;
			end
			S_DRAIN: begin
				if (inflight_q == '0) state_n = S_FILL;
			end
			S_FILL: begin
				if (!fill_more) state_n = m_small ? S_DONE : S_COL;
			end
			S_COL: begin
				if (col_q > nu_eff || rank_q >= rows_eff) state_n = S_DONE;
				else state_n = S_SRCH_RD;
			end
			S_SRCH_RD:  state_n = S_SRCH_CHK;
			S_SRCH_CHK: begin
				if (rdata0 != '0) state_n = S_PIVOT;
				else if (i_last) state_n = S_COL;
				else state_n = S_SRCH_RD;
			end
			S_PIVOT: begin
				if (col_q == nu_eff) state_n = S_DONE;
				else if (piv_q != rank_q) state_n = S_SWAP_RD;
				else state_n = S_POW_RD;
			end
			S_SWAP_RD:  state_n = S_SWAP_WR0;
			S_SWAP_WR0: state_n = S_SWAP_WR1;
			S_SWAP_WR1: state_n = (j_q == nu_eff) ? S_POW_RD : S_SWAP_RD;
			S_POW_RD:   state_n = S_POW_LD;
			S_POW_LD:   state_n = S_POW_ISS0;
			S_POW_ISS0: state_n = S_POW_ISS1;
			S_POW_ISS1: state_n = S_POW_WAIT;
			S_POW_WAIT: begin
				if (inflight_q == '0) begin
					state_n = (pow_cnt_q == POW_CNT_W'(WORD_W - 1)) ? S_SCALE_RD : S_POW_ISS0;
				end
			end
			S_SCALE_RD:  state_n = S_SCALE_ISS;
			S_SCALE_ISS: state_n = (j_q == nu_eff) ? S_SCALE_WAIT : S_SCALE_RD;
			S_SCALE_WAIT: begin
				if (inflight_q == '0) state_n = S_ELIM_ROW;
			end
			S_ELIM_ROW: state_n = (i_q >= rows_eff) ? S_ELIM_WAIT : S_ELIM_LEAD;
			S_ELIM_LEAD: state_n = (rdata0 == '0) ? S_ELIM_ROW : S_ELIM_RD;
			S_ELIM_RD:   state_n = S_ELIM_ISS;
			S_ELIM_ISS:  state_n = (j_q == nu_eff) ? S_ELIM_ROW : S_ELIM_RD;
			S_ELIM_WAIT: begin
				if (inflight_q == '0) state_n = S_COL;
			end
			S_DONE:  state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// Outputs: read rows, pipe requests, controller writes
	always_comb begin
		row0       = i_q;
		col0       = j_q;
		op_valid   = 1'b0;
		op         = '{a: '0, f: '0, b: '0};
		op_dst     = DST_MEM;
		op_addr    = addr1;
		ctrl_we    = 1'b0;
		ctrl_waddr = addr1;
		ctrl_wdata = '0;
		case (state_q)
			S_IDLE: begin
				op_valid = start && load_room;
				op       = '{a: entry, f: '0, b: '0};
				op_addr  = AW'(load_pos_q);
			end
			S_FILL: begin
				ctrl_we    = fill_more;
				ctrl_waddr = AW'(load_pos_q);
			end
			S_SRCH_RD: col0 = col_q;
			S_SWAP_RD: row0 = piv_q;
			S_SWAP_WR0: begin
				ctrl_we    = 1'b1;
				ctrl_wdata = rdata0;
			end
			S_SWAP_WR1: begin
				row0       = piv_q;
				ctrl_we    = 1'b1;
				ctrl_waddr = addr0;
				ctrl_wdata = tmp_q;
			end
			S_POW_RD: begin
				row0 = rank_q;
				col0 = col_q;
			end
			S_POW_ISS0: begin
				op_valid = 1'b1;
				op       = '{a: '0, f: base_q, b: base_q};
				op_dst   = DST_BASE;
			end
			S_POW_ISS1: begin
				op_valid = exp_q[0];
				op       = '{a: '0, f: acc_q, b: base_q};
				op_dst   = DST_ACC;
			end
			S_SCALE_RD: row0 = rank_q;
			S_SCALE_ISS: begin
				op_valid = 1'b1;
				op       = '{a: '0, f: acc_q, b: rdata0};
			end
			S_ELIM_ROW: col0 = col_q;
			S_ELIM_ISS: begin
				op_valid = 1'b1;
				op       = '{a: rdata0, f: f_q, b: rdata1};
				op_addr  = addr0;
			end
			default: begin
			end
		endcase
	end

	assign red_dst  = dst_t'(red_tag[DST_W-1:0]);
	assign red_addr = red_tag[TW-1:DST_W];
	assign chain_we = red_valid && (red_dst == DST_MEM);
	assign we       = chain_we || ctrl_we;
	assign waddr    = chain_we ? red_addr : ctrl_waddr;
	assign wdata    = chain_we ? (m_small ? '0 : red_rem) : ctrl_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_q        <= MODULUS_RESET;
			rc_q       <= '0;
			nu_q       <= '0;
			load_pos_q <= '0;
			rank_q     <= '0;
			col_q      <= '0;
			ok_q       <= 1'b0;
			inflight_q <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS:       m_q  <= cfg_data;
					REG_ROW_COUNT:     rc_q <= cfg_data[6:0];
					REG_UNKNOWN_COUNT: nu_q <= cfg_data[5:0];
					default: begin
					end
				endcase
			end
			case ({op_valid, red_valid})
				2'b10:   inflight_q <= inflight_q + INFLIGHT_W'(1);
				2'b01:   inflight_q <= inflight_q - INFLIGHT_W'(1);
				default: inflight_q <= inflight_q;
			endcase
			case (state_q)
				S_IDLE: begin
					if (start && load_room) load_pos_q <= load_pos_q + LPW'(1);
				end
				S_FILL: begin
					if (fill_more) begin
						load_pos_q <= load_pos_q + LPW'(1);
					end else begin
						rank_q <= '0;
						col_q  <= '0;
						ok_q   <= 1'b1;
					end
				end
				S_COL: begin
					if (col_q > nu_eff || rank_q >= rows_eff) ok_q <= 1'b1;
				end
				S_SRCH_CHK: begin
					if (rdata0 == '0 && i_last) col_q <= col_q + CW'(1);
				end
				S_PIVOT: begin
					if (col_q == nu_eff) ok_q <= 1'b0;
				end
				S_ELIM_WAIT: begin
					if (inflight_q == '0) begin
						rank_q <= rank_q + RW'(1);
						col_q  <= col_q + CW'(1);
					end
				end
				S_DONE: begin
					load_pos_q <= '0;
					rank_q     <= '0;
					col_q      <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		if (red_valid && red_dst == DST_BASE) base_q <= red_rem;
		if (red_valid && red_dst == DST_ACC) acc_q <= red_rem;
		case (state_q)
			S_COL: i_q <= rank_q;
			S_SRCH_CHK: begin
				if (rdata0 != '0) piv_q <= i_q;
				else i_q <= i_q + RW'(1);
			end
			S_PIVOT: j_q <= '0;
			S_SWAP_WR0: tmp_q <= rdata1;
			S_SWAP_WR1: j_q <= j_q + CW'(1);
			S_POW_LD: begin
				base_q    <= rdata0;
				acc_q     <= WORD_W'(1);
				exp_q     <= m_q - WORD_W'(2);
				pow_cnt_q <= '0;
			end
			S_POW_WAIT: begin
				if (inflight_q == '0) begin
					exp_q     <= exp_q >> 1;
					pow_cnt_q <= pow_cnt_q + POW_CNT_W'(1);
					j_q       <= col_q;
				end
			end
			S_SCALE_ISS: j_q <= j_q + CW'(1);
			S_SCALE_WAIT: i_q <= rank_q + RW'(1);
			S_ELIM_LEAD: begin
				if (rdata0 == '0) begin
					i_q <= i_q + RW'(1);
				end else begin
					f_q <= m_q - rdata0;
					j_q <= col_q;
				end
			end
			S_ELIM_ISS: begin
				if (j_q == nu_eff) i_q <= i_q + RW'(1);
				else j_q <= j_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	gfls_modred #(.TW(TW)) u_modred (
		.clk      (clk),
		.arst_n   (arst_n),
		.m        (m_q),
		.in_valid (op_valid),
		.in_op    (op),
		.in_tag   ({op_addr, op_dst}),
		.out_valid(red_valid),
		.out_rem  (red_rem),
		.out_tag  (red_tag)
	);

	gfls_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(addr0),
		.raddr1(addr1),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	a_done_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (inflight_q == '0))
		else $error("result given while words still in the cell chain");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(chain_we && ctrl_we))
		else $error("cell chain and controller write the store together");

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> (!busy && inflight_q == '0))
		else $error("config taken while work is pending");

endmodule

// ----- dv/tb_gf_p_linear_system_consistency_core.sv -----
// Testbench for the prime-field linear system consistency core: table-driven and random matrices.
`timescale 1ns / 100ps

module tb_gf_p_linear_system_consistency_core;
	import gfls_pkg::*;

	localparam int STORE_DEPTH = 64 * 64;
	localparam int CYCLE_LIMIT = 50_000_000;
	localparam int ITEM_TARGET = 1100;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [31:0] entry;
	logic last_entry;
	logic done;
	logic consistent;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0] cfg_data;

	gf_p_linear_system_consistency_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.entry(entry),
		.last_entry(last_entry),
		.done(done),
		.consistent(consistent),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the block's registers and matrix store
	bit [31:0] field_mod;
	bit [6:0] row_reg;
	bit [5:0] unk_reg;
	bit [31:0] gf_store [STORE_DEPTH];
	int fill_pos;

	bit verdict_q [$];
	int errors;
	int words_sent;
	longint cycles;

	typedef struct {
		bit do_cfg;
		bit [31:0] m;
		bit [6:0] r;
		bit [5:0] u;
		int n;
		int verdict; // -1: take the predicted value
	} dir_case_t;

	dir_case_t dir_tab [10];
	bit [31:0] dir_words [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// results cannot be held off: check on every done cycle
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				$error("consistent: unexpected word, actual %0d", consistent);
				errors++;
			end else begin
				if (consistent !== verdict_q[0]) begin
					$error("consistent: expected %0d, actual %0d", verdict_q[0], consistent);
					errors++;
				end
				verdict_q.pop_front();
			end
		end
	end

	function automatic longint unsigned gf_pow(longint unsigned b, longint unsigned ex,
			longint unsigned m);
		longint unsigned acc;
		acc = 1 % m;
		b = b % m;
		while (ex != 0) begin
			if (ex[0])
				acc = acc * b % m;
			b = b * b % m;
			ex = ex >> 1;
		end
		return acc;
	endfunction

	function automatic bit gf_solve();
		longint unsigned m, inv, f, pv, lead;
		int rows, nu, w, total, rank, col, piv, i, j;
		bit [31:0] t;
		m = field_mod;
		rows = (row_reg > 64) ? 64 : row_reg;
		nu = unk_reg;
		w = nu + 1;
		total = rows * w;
		for (i = fill_pos; i < total && i < STORE_DEPTH; i++)
			gf_store[i] = 32'd0;
		if (m < 2)
			return 1'b1;
		rank = 0;
		for (col = 0; col <= nu && rank < rows; col++) begin
			piv = rows;
			for (i = rank; i < rows; i++) begin
				if (gf_store[i*w+col] != 0) begin
					piv = i;
					break;
				end
			end
			if (piv == rows)
				continue;
			if (col == nu)
				return 1'b0;
			if (piv != rank) begin
				for (j = 0; j < w; j++) begin
					t = gf_store[piv*w+j];
					gf_store[piv*w+j] = gf_store[rank*w+j];
					gf_store[rank*w+j] = t;
				end
			end
			inv = gf_pow(gf_store[rank*w+col], m - 2, m);
			for (j = col; j <= nu; j++)
				gf_store[rank*w+j] = 32'(gf_store[rank*w+j] * inv % m);
			for (i = rank + 1; i < rows; i++) begin
				lead = gf_store[i*w+col];
				if (lead == 0)
					continue;
				f = m - lead;
				for (j = col; j <= nu; j++) begin
					pv = gf_store[rank*w+j];
					if (pv != 0)
						gf_store[i*w+j] = 32'((gf_store[i*w+j] + f * pv) % m);
				end
			end
			rank++;
		end
		return 1'b1;
	endfunction

	// returns the verdict, or -1 when the word gives no result
	function automatic int load_word(bit [31:0] e, bit l);
		bit ok;
		if (fill_pos < STORE_DEPTH) begin
			gf_store[fill_pos] = (field_mod < 2) ? 32'd0 : e % field_mod;
			fill_pos++;
		end
		if (!l)
			return -1;
		ok = gf_solve();
		fill_pos = 0;
		return ok;
	endfunction

	task automatic idle_gap();
		int k, n;
		k = $urandom_range(0, 99);
		n = (k < 60) ? 0 : (k < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// forced: -1 uses the prediction, else the typed-in verdict is queued
	task automatic send_word(bit [31:0] e, bit l, int forced);
		int v;
		start <= 1'b1;
		entry <= e;
		last_entry <= l;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		words_sent++;
		v = load_word(e, l);
		if (v >= 0)
			verdict_q.insert(verdict_q.size(), (forced >= 0) ? forced[0] : v[0]);
		idle_gap();
	endtask

	// hold until no verdict is pending and the block has gone quiet
	task automatic settle();
		start <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(bit [CFG_IDX_W-1:0] idx, bit [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODULUS: field_mod = d;
			REG_ROW_COUNT: row_reg = d[6:0];
			REG_UNKNOWN_COUNT: unk_reg = d[5:0];
			default: ;
		endcase
	endtask

	task automatic set_shape(bit [31:0] m, bit [6:0] r, bit [5:0] u);
		settle();
		cfg_write(REG_MODULUS, m);
		cfg_write(REG_ROW_COUNT, {25'($urandom), r});
		cfg_write(REG_UNKNOWN_COUNT, {26'($urandom), u});
	endtask

	function automatic bit [31:0] pick_modulus();
		int k;
		k = $urandom_range(0, 19);
		case (k)
			0: return 32'd3;
			1, 2: return 32'd5;
			3, 4: return 32'd7;
			5: return 32'd13;
			6, 7: return 32'd65537;
			8, 9: return 32'd2147483647;
			10, 11, 12: return 32'd4294967291;
			13: return 32'd4294967295;
			14: return $urandom_range(0, 1);
			default: return $urandom | 32'd3;
		endcase
	endfunction

	function automatic bit [31:0] pick_entry(bit [31:0] m);
		int k;
		k = $urandom_range(0, 9);
		if (k < 3)
			return 32'd0;
		if (k < 5)
			return $urandom_range(1, 3);
		if (k < 8 && m >= 2)
			return $urandom % m;
		return $urandom;
	endfunction

	task automatic send_matrix(int n, bit [31:0] m);
		for (int i = 0; i < n; i++)
			send_word(pick_entry(m), i == n - 1, -1);
	endtask

	initial begin
		int pos, total, n, k, phase;
		bit [31:0] m;
		bit [6:0] r;
		bit [5:0] u;

		arst_n = 1'b0;
		start = 1'b0;
		entry = '0;
		last_entry = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		errors = 0;
		words_sent = 0;
		field_mod = MODULUS_RESET;
		row_reg = '0;
		unk_reg = '0;
		fill_pos = 0;

		// empty matrix under reset defaults
		dir_tab[0] = '{1'b0, 32'd0, 7'd0, 6'd0, 1, 1};
		// pivot lands in the right-hand side
		dir_tab[1] = '{1'b1, 32'd7, 7'd1, 6'd1, 2, 0};
		// entries above the modulus
		dir_tab[2] = '{1'b1, 32'd7, 7'd1, 6'd1, 2, 1};
		// modulus zero and one
		dir_tab[3] = '{1'b1, 32'd0, 7'd1, 6'd0, 1, 1};
		dir_tab[4] = '{1'b1, 32'd1, 7'd1, 6'd0, 1, 1};
		dir_tab[5] = '{1'b1, 32'hFFFF_FFFB, 7'd2, 6'd1, 4, 0};
		// row count past the store, too few words
		dir_tab[6] = '{1'b1, 32'd5, 7'd127, 6'd0, 3, 0};
		// modulus that is not prime, then a short matrix under modulus three
		dir_tab[7] = '{1'b1, 32'hFFFF_FFFF, 7'd2, 6'd2, 6, -1};
		dir_tab[8] = '{1'b1, 32'd3, 7'd3, 6'd1, 2, -1};
		// words beyond the matrix are ignored
		dir_tab[9] = '{1'b1, 32'd11, 7'd1, 6'd1, 4, 1};
		dir_words = '{32'hFFFF_FFFF,
			32'd0, 32'd5,
			32'd3, 32'd9,
			32'd5,
			32'd1,
			32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd2,
			32'd0, 32'd0, 32'd1,
			32'h8000_0001, 32'd7, 32'hFFFF_FFFE, 32'd2, 32'h1234_5678, 32'hFFFF_FFFF,
			32'd1, 32'd2,
			32'd0, 32'd0, 32'd4, 32'd4};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pos = 0;
		foreach (dir_tab[c]) begin
			if (dir_tab[c].do_cfg)
				set_shape(dir_tab[c].m, dir_tab[c].r, dir_tab[c].u);
			for (int i = 0; i < dir_tab[c].n; i++)
				send_word(dir_words[pos+i], i == dir_tab[c].n - 1, dir_tab[c].verdict);
			pos += dir_tab[c].n;
		end

		phase = 0;
		while (words_sent < ITEM_TARGET) begin
			phase++;
			m = pick_modulus();
			r = 7'($urandom_range(0, 3));
			u = 6'($urandom_range(0, 3));
			if (phase == 5) begin
				r = 7'd64;
				u = 6'd1;
			end else if (phase == 10) begin
				r = 7'd1;
				u = 6'd63;
			end
			set_shape(m, r, u);
			if (phase == 20) begin
				// unused index: must leave the registers alone
				cfg_write(2'd3, $urandom);
			end
			k = $urandom_range(1, 4);
			for (int t = 0; t < k; t++) begin
				if ($urandom_range(0, 9) == 0)
					settle();
				total = ((r > 64) ? 64 : r) * (u + 1);
				case ($urandom_range(0, 9))
					7: n = (total > 0) ? $urandom_range(1, total) : 1;
					8: n = total + $urandom_range(1, 3);
					9: n = $urandom_range(1, total + 2);
					default: n = total;
				endcase
				if (n == 0)
					n = 1;
				send_matrix(n, m);
			end
		end

		start <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
